### design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants for the genome compatibility distance block.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int MaxInnovationsDefault = 1024;
  localparam int WeightBitsDefault     = 16;
  localparam int InnovBits             = 10;
  localparam int CountBits             = 11;
  localparam int NodeBits              = 8;
  localparam int CoefBits              = 16;
  localparam int DistBits              = 32;
  localparam int SmallNodes            = 20;
  localparam int QuotBits              = 64;
  localparam int DivBits               = 17;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_EXCESS   = 2'd0;
  localparam logic [1:0] REG_DISJOINT = 2'd1;
  localparam logic [1:0] REG_WEIGHT   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic walk_start;
    logic walk_step;
    logic clear_step;
    logic prod_step;
    logic div_init;
    logic div_step;
    logic done;
  } gcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;
    logic prod_last;
    logic div_last;
  } gcd_status_t;

endpackage

### design/gcd_datapath.sv
// ----------------------------------------------------------------------------
// gcd_datapath
// Gene tables, walk counters, numerator formation and a radix-2 divider.
// ----------------------------------------------------------------------------
module gcd_datapath #(
  parameter int MAX_INNOVATIONS = gcd_pkg::MaxInnovationsDefault,
  parameter int WEIGHT_BITS     = gcd_pkg::WeightBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gcd_pkg::gcd_cmd_t                   cmd,
  output gcd_pkg::gcd_status_t                status,
  input  logic [gcd_pkg::InnovBits-1:0]       innovation,
  input  logic signed [WEIGHT_BITS-1:0]       weight,
  input  logic [gcd_pkg::NodeBits-1:0]        node_count_a,
  input  logic [gcd_pkg::NodeBits-1:0]        node_count_b,
  input  logic [gcd_pkg::CoefBits-1:0]        excess_coefficient,
  input  logic [gcd_pkg::CoefBits-1:0]        disjoint_coefficient,
  input  logic [gcd_pkg::CoefBits-1:0]        weight_coefficient,
  output logic [gcd_pkg::DistBits-1:0]        distance,
  output logic [gcd_pkg::CountBits-1:0]       matching_count,
  output logic [gcd_pkg::CountBits-1:0]       disjoint_count,
  output logic [gcd_pkg::CountBits-1:0]       excess_count
);
  import gcd_pkg::*;

  localparam int AddrBits = $clog2(MAX_INNOVATIONS);
  localparam int WalkBits = AddrBits + 1;
  localparam int DiffBits = WEIGHT_BITS + 1;
  localparam int SumBits  = DiffBits + WalkBits;
  localparam int HalfBits = (SumBits + 1) / 2;
  localparam int WProdBits = CoefBits + SumBits;
  localparam int CtBits   = CoefBits + WalkBits + 1;
  localparam int WpBits   = CoefBits + HalfBits;
  localparam int DivCntBits = $clog2(QuotBits + 1);
  localparam int NumBits  = 64;
  localparam logic [WalkBits-1:0] WalkLast = WalkBits'(MAX_INNOVATIONS - 1);

  // Gene tables: presence bits and weights in memories.
  logic                       pres_a [MAX_INNOVATIONS];
  logic                       pres_b [MAX_INNOVATIONS];
  logic [WEIGHT_BITS-1:0]     mem_a [MAX_INNOVATIONS];
  logic [WEIGHT_BITS-1:0]     mem_b [MAX_INNOVATIONS];
  logic [WEIGHT_BITS-1:0]     rd_a;
  logic [WEIGHT_BITS-1:0]     rd_b;
  logic [InnovBits:0]         top_a;
  logic [InnovBits:0]         top_b;
  logic                       has_a;
  logic                       has_b;
  logic                       in_range;
  logic [AddrBits-1:0]        wr_addr;

  assign in_range = ({1'b0, innovation} < (InnovBits+1)'(MAX_INNOVATIONS)) ||
                    (MAX_INNOVATIONS > (1 << InnovBits));
  assign wr_addr  = AddrBits'(innovation);

  // Walk address and the registered stage that sees read data.
  logic [WalkBits-1:0] walk_idx;
  logic [AddrBits-1:0] rd_addr;
  logic                stage_valid;
  logic                stage_pa;
  logic                stage_pb;
  logic [WalkBits-1:0] stage_idx;
  logic                both;
  logic [InnovBits:0]  limit;

  assign rd_addr = walk_idx[AddrBits-1:0];
  assign status.walk_last = (walk_idx == WalkLast);

  always_ff @(posedge clk) begin
    if (cmd.load_a && in_range) mem_a[wr_addr] <= weight;
    if (cmd.load_b && in_range) mem_b[wr_addr] <= weight;
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
  end

  // Presence bits are set on a load and cleared as the walk or the clearing
  // pass after reset passes each address.
  always_ff @(posedge clk) begin
    if (cmd.load_a && in_range) pres_a[wr_addr] <= 1'b1;
    else if (cmd.walk_step || cmd.clear_step) pres_a[rd_addr] <= 1'b0;
    if (cmd.load_b && in_range) pres_b[wr_addr] <= 1'b1;
    else if (cmd.walk_step || cmd.clear_step) pres_b[rd_addr] <= 1'b0;
    if (cmd.walk_step) begin
      stage_pa  <= pres_a[rd_addr];
      stage_pb  <= pres_b[rd_addr];
      stage_idx <= walk_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_a       <= '0;
      top_b       <= '0;
      has_a       <= 1'b0;
      has_b       <= 1'b0;
      walk_idx    <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (cmd.load_a && in_range) begin
        if (!has_a || {1'b0, innovation} > top_a) top_a <= {1'b0, innovation};
        has_a <= 1'b1;
      end
      if (cmd.load_b && in_range) begin
        if (!has_b || {1'b0, innovation} > top_b) top_b <= {1'b0, innovation};
        has_b <= 1'b1;
      end
      stage_valid <= cmd.walk_step;
      if (cmd.walk_start) begin
        walk_idx <= '0;
        both  <= has_a && has_b;
        limit <= (top_a < top_b) ? top_a : top_b;
      end else if (cmd.walk_step || cmd.clear_step) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (cmd.done) begin
        top_a <= '0;
        top_b <= '0;
        has_a <= 1'b0;
        has_b <= 1'b0;
      end
    end
  end

  // Accumulate counts and the weight difference sum.
  logic signed [DiffBits-1:0] diff;
  logic [DiffBits-1:0]        adiff;
  logic [WalkBits-1:0]        cnt_m;
  logic [WalkBits-1:0]        cnt_d;
  logic [WalkBits-1:0]        cnt_e;
  logic [SumBits-1:0]         wsum;

  assign diff  = DiffBits'($signed(rd_a)) - DiffBits'($signed(rd_b));
  assign adiff = diff[DiffBits-1] ? DiffBits'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cnt_m <= '0;
      cnt_d <= '0;
      cnt_e <= '0;
      wsum  <= '0;
    end else if (stage_valid) begin
      if (stage_pa && stage_pb) begin
        cnt_m <= cnt_m + 1'b1;
        wsum  <= wsum + SumBits'(adiff);
      end else if (stage_pa || stage_pb) begin
        if (both && ((InnovBits+1 > WalkBits) ?
            ((InnovBits+1)'(stage_idx) <= limit) :
            (stage_idx <= WalkBits'(limit))))
          cnt_d <= cnt_d + 1'b1;
        else
          cnt_e <= cnt_e + 1'b1;
      end
    end
  end

  // Numerator in three steps: the count terms and the weight term in two halves
  // are multiplied, the two halves are joined, then the sum is formed.
  logic [1:0]                     prod_phase;
  logic [CtBits-1:0]              count_term;
  logic [WpBits-1:0]              wp_lo;
  logic [WpBits-1:0]              wp_hi;
  logic [WProdBits-1:0]           wprod;
  logic [NumBits-1:0]             numer;

  assign status.prod_last = (prod_phase == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_phase <= '0;
    end else if (cmd.prod_step) begin
      prod_phase <= status.prod_last ? 2'd0 : prod_phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_step) begin
      case (prod_phase)
        2'd0: begin
          count_term <= CtBits'(excess_coefficient) * CtBits'(cnt_e) +
                        CtBits'(disjoint_coefficient) * CtBits'(cnt_d);
          wp_lo <= WpBits'(weight_coefficient) * WpBits'(wsum[HalfBits-1:0]);
          wp_hi <= WpBits'(weight_coefficient) * WpBits'(wsum[SumBits-1:HalfBits]);
        end
        2'd1: begin
          wprod <= WProdBits'(wp_lo) + (WProdBits'(wp_hi) << HalfBits);
        end
        default: begin
          numer <= NumBits'({count_term, 8'd0}) + NumBits'(wprod);
        end
      endcase
    end
  end

  // Node counts are captured with the compute beat.
  logic [NodeBits-1:0]    nmax;
  logic                   nodes_small;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      nmax        <= (node_count_a > node_count_b) ? node_count_a : node_count_b;
      nodes_small <= node_count_a < NodeBits'(SmallNodes) &&
                     node_count_b < NodeBits'(SmallNodes);
    end
  end

  // Restoring divider, one quotient bit per cycle; divisor 256*(N<20 ? 1 : N).
  logic [DivBits-1:0]     divisor;
  logic [NumBits-1:0]     quot;
  logic [DivBits:0]       rem;
  logic [DivCntBits-1:0]  div_cnt;
  logic [DivBits:0]       trial;

  assign trial = {rem[DivBits-1:0], quot[NumBits-1]};
  assign status.div_last = (div_cnt == DivCntBits'(QuotBits - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      if (nodes_small)
        divisor <= DivBits'(256);
      else
        divisor <= {1'b0, nmax, 8'd0};
      quot    <= numer;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem  <= trial - {1'b0, divisor};
        quot <= {quot[NumBits-2:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[NumBits-2:0], 1'b0};
      end
    end
  end

  // Result, saturated.
  always_comb begin
    distance       = (|quot[NumBits-1:DistBits]) ? '1 : quot[DistBits-1:0];
    matching_count = (WalkBits > CountBits && |(cnt_m >> CountBits)) ? '1 :
                     CountBits'(cnt_m);
    disjoint_count = (WalkBits > CountBits && |(cnt_d >> CountBits)) ? '1 :
                     CountBits'(cnt_d);
    excess_count   = (WalkBits > CountBits && |(cnt_e >> CountBits)) ? '1 :
                     CountBits'(cnt_e);
  end

endmodule

### design/gcd_control.sv
// ----------------------------------------------------------------------------
// gcd_control
// Sequencer for clearing, load, walk, numerator and divide phases.
// ----------------------------------------------------------------------------
module gcd_control (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            op,
  input  gcd_pkg::gcd_status_t  status,
  output gcd_pkg::gcd_cmd_t     cmd,
  output logic                  busy,
  output logic                  strobe
);
  import gcd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WALK  = 7'b0000010,
    ST_FLUSH = 7'b0000100,
    ST_PROD  = 7'b0001000,
    ST_DIVI  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.walk_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load_a = accept && (op == OP_LOAD_A);
        cmd.load_b = accept && (op == OP_LOAD_B);
        if (accept && op == OP_COMPUTE) begin
          cmd.walk_start = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod_step = 1'b1;
        if (status.prod_last) state_next = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.done = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.done;
    end
  end

  // A result beat only follows the divide phase.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(state == ST_DIV))
    else $error("result beat without divide");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !status.walk_last) |=> state == ST_WALK)
    else $error("walk left early");
  assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("result while busy");

endmodule

### design/genome_compatibility_distance.sv
// ----------------------------------------------------------------------------
// genome_compatibility_distance
// Compatibility distance between two genomes loaded gene by gene.
// ----------------------------------------------------------------------------
// Channel  | Handshake            | Payload
// input    | start / busy         | op, innovation, weight, node counts
// result   | strobe (one cycle)   | distance, matching/disjoint/excess counts
// config   | APB write/read       | three 16-bit coefficients
//
// A gene load does not raise busy; a new beat can follow at once.
// A compute beat holds busy through a walk over every innovation, a flush state,
// the numerator steps, a divider setup state and the divider steps for the
// 64-bit quotient. The strobe rises in the same cycle as busy falls.
// Reset starts a pass that clears the presence tables, with busy high throughout.
// The result receiver cannot stall; a result is flagged by strobe for one cycle.
// ----------------------------------------------------------------------------
module genome_compatibility_distance #(
  parameter int MAX_INNOVATIONS = gcd_pkg::MaxInnovationsDefault,
  parameter int WEIGHT_BITS     = gcd_pkg::WeightBitsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic [gcd_pkg::InnovBits-1:0]      innovation,
  input  logic signed [WEIGHT_BITS-1:0]      weight,
  input  logic [gcd_pkg::NodeBits-1:0]       node_count_a,
  input  logic [gcd_pkg::NodeBits-1:0]       node_count_b,
  output logic                               strobe,
  output logic [gcd_pkg::DistBits-1:0]       distance,
  output logic [gcd_pkg::CountBits-1:0]      matching_count,
  output logic [gcd_pkg::CountBits-1:0]      disjoint_count,
  output logic [gcd_pkg::CountBits-1:0]      excess_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gcd_pkg::*;

  gcd_cmd_t    cmd;
  gcd_status_t status;
  logic [CoefBits-1:0] excess_coefficient;
  logic [CoefBits-1:0] disjoint_coefficient;
  logic [CoefBits-1:0] weight_coefficient;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      excess_coefficient   <= CoefBits'(256);
      disjoint_coefficient <= CoefBits'(256);
      weight_coefficient   <= CoefBits'(102);
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        REG_EXCESS:   excess_coefficient   <= pwdata[CoefBits-1:0];
        REG_DISJOINT: disjoint_coefficient <= pwdata[CoefBits-1:0];
        REG_WEIGHT:   weight_coefficient   <= pwdata[CoefBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EXCESS:   prdata = {16'd0, excess_coefficient};
      REG_DISJOINT: prdata = {16'd0, disjoint_coefficient};
      REG_WEIGHT:   prdata = {16'd0, weight_coefficient};
      default:      prdata = '0;
    endcase
  end

  gcd_control u_control (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  gcd_datapath #(
    .MAX_INNOVATIONS (MAX_INNOVATIONS),
    .WEIGHT_BITS     (WEIGHT_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .innovation           (innovation),
    .weight               (weight),
    .node_count_a         (node_count_a),
    .node_count_b         (node_count_b),
    .excess_coefficient   (excess_coefficient),
    .disjoint_coefficient (disjoint_coefficient),
    .weight_coefficient   (weight_coefficient),
    .distance             (distance),
    .matching_count       (matching_count),
    .disjoint_count       (disjoint_count),
    .excess_count         (excess_count)
  );

endmodule
